>>> hw/rtl/ctkc_pkg.sv
// ----------------------------------------------------------------------------
// ctkc_pkg
// Shared types, codes and helpers for the cook-timer keypad controller.
// ----------------------------------------------------------------------------
package ctkc_pkg;

	localparam int MAX_TEMP_DEFAULT = 250;

	localparam logic [1:0] ACT_KEY  = 2'd0;
	localparam logic [1:0] ACT_TICK = 2'd1;
	localparam logic [1:0] ACT_MENU = 2'd2;

	localparam logic [3:0] KEY_START = 4'd4;
	localparam logic [3:0] KEY_PAUSE = 4'd5;
	localparam logic [3:0] KEY_STOP  = 4'd6;
	localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
	localparam logic [3:0] KEY_CLEAR = 4'd10;
	localparam logic [3:0] KEY_ENTER = 4'd11;

	localparam logic [1:0] FLD_MICRO_MIN = 2'd0;
	localparam logic [1:0] FLD_MICRO_SEC = 2'd1;
	localparam logic [1:0] FLD_CONV_TEMP = 2'd0;
	localparam logic [1:0] FLD_CONV_MIN  = 2'd1;
	localparam logic [1:0] FLD_CONV_SEC  = 2'd2;

	localparam logic [5:0] SEC_MAX = 6'd59;
	localparam logic [1:0] TEMP_DIGITS_MAX = 2'd3;

	typedef enum logic [1:0] {
		MODE_MENU  = 2'd0,
		MODE_MICRO = 2'd1,
		MODE_CONV  = 2'd2,
		MODE_RUN   = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  field;
		logic [6:0]  minutes;
		logic [5:0]  seconds;
		logic [7:0]  temp;
		logic [1:0]  tcnt;
		logic [7:0]  ctemp;
		logic        run;
		logic        pause;
		logic        fan;
		logic        ten;
	} state_t;

	// Low decimal digit of a value below 128, by reciprocal multiplication.
	function automatic logic [3:0] low_digit(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  q;
		logic [6:0]  r;
		prod = {8'd0, v} * 15'd205;
		q    = prod[14:11];
		r    = v - ({3'd0, q} * 7'd10);
		return r[3:0];
	endfunction

	// Shifts a decimal digit into a two-digit field.
	function automatic logic [6:0] shift_digit(input logic [6:0] v, input logic [3:0] k);
		logic [6:0] d;
		d = {3'd0, low_digit(v)};
		return (d * 7'd10) + {3'd0, k};
	endfunction

endpackage

>>> hw/rtl/cook_timer_keypad_controller.sv
// ----------------------------------------------------------------------------
// cook_timer_keypad_controller
// Appliance cook-timer: keypad entry, menu selection and second countdown.
// ----------------------------------------------------------------------------
// Each accepted item (keypad press, one-second tick or menu selection) yields
// one registered result item, carrying the full screen and flag state.
// The block takes one item per clock; the state register doubles as the
// result register, so a new item is taken whenever the result is consumed in
// the same cycle or no result is pending.
module cook_timer_keypad_controller import ctkc_pkg::*; #(
	parameter int MAX_TEMP = MAX_TEMP_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // key_code[3:0], menu_choice[4], zero fill
	input  logic [1:0]  s_tuser,  // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// screen_mode[1:0], edit_field[3:2], minutes_shown[10:4],
	// seconds_shown[16:11], temp_entry[24:17], set_temp[32:25], running[33],
	// paused[34], fan_on[35], tick_enable[36], done_pulse[37], zero fill
	output logic [39:0] m_tdata
);

	state_t st_q;
	state_t st_nxt;
	logic   done_q;
	logic   done_nxt;
	logic   m_tvalid_q;
	logic   accept;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	ctkc_next #(
		.MAX_TEMP(MAX_TEMP)
	) u_next (
		.cur        (st_q),
		.action     (s_tuser),
		.key_code   (s_tdata[3:0]),
		.menu_choice(s_tdata[4]),
		.nxt        (st_nxt),
		.done       (done_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= '0;
			done_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				st_q   <= st_nxt;
				done_q <= done_nxt;
			end
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, done_q, st_q.ten, st_q.fan, st_q.pause, st_q.run,
		st_q.ctemp, st_q.temp, st_q.seconds, st_q.minutes, st_q.field, st_q.mode};

	a_run_no_pause: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.run |-> !st_q.pause)
		else $error("running and paused both set");

	a_run_in_run_mode: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.run |-> (st_q.mode == MODE_RUN))
		else $error("countdown active outside the running screen");

	a_done_to_menu: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ((st_q.mode == MODE_MENU) && !st_q.run && !st_q.fan))
		else $error("done pulse without return to menu");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted item produced no result");

endmodule

>>> hw/rtl/ctkc_next.sv
// ----------------------------------------------------------------------------
// ctkc_next
// Next-state logic: applies one keypad, tick or menu item to the state.
// ----------------------------------------------------------------------------
module ctkc_next import ctkc_pkg::*; #(
	parameter int MAX_TEMP = MAX_TEMP_DEFAULT
) (
	input  state_t     cur,
	input  logic [1:0] action,
	input  logic [3:0] key_code,
	input  logic       menu_choice,
	output state_t     nxt,
	output logic       done
);

	localparam logic [11:0] TempCap = 12'(MAX_TEMP);

	logic [6:0]  min_shift;
	logic [6:0]  sec_shift;
	logic [11:0] temp_wide;
	logic [11:0] temp_clamped;
	logic        is_digit;

	assign is_digit  = (key_code <= KEY_DIGIT_MAX);
	assign min_shift = shift_digit(cur.minutes, key_code);
	assign sec_shift = shift_digit({1'b0, cur.seconds}, key_code);
	assign temp_wide = (cur.tcnt == 2'd0) ? {8'd0, key_code}
		: ({4'd0, cur.temp} * 12'd10) + {8'd0, key_code};
	assign temp_clamped = (temp_wide > TempCap) ? TempCap : temp_wide;

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		case (action)
			ACT_KEY: begin
				case (cur.mode)
					MODE_MICRO: begin
						if (is_digit) begin
							if (cur.field == FLD_MICRO_MIN) begin
								nxt.minutes = min_shift;
							end else if (sec_shift <= {1'b0, SEC_MAX}) begin
								nxt.seconds = sec_shift[5:0];
							end
						end else if (key_code == KEY_CLEAR) begin
							nxt.minutes = '0;
							nxt.seconds = '0;
							nxt.field   = FLD_MICRO_MIN;
						end else if (key_code == KEY_ENTER) begin
							if (cur.field == FLD_MICRO_MIN) begin
								nxt.field = FLD_MICRO_SEC;
							end else begin
								nxt.run   = 1'b1;
								nxt.pause = 1'b0;
								nxt.field = FLD_MICRO_MIN;
								nxt.mode  = MODE_RUN;
								nxt.fan   = 1'b1;
								nxt.ten   = 1'b1;
							end
						end
					end
					MODE_CONV: begin
						if (is_digit) begin
							if (cur.field == FLD_CONV_TEMP) begin
								nxt.temp = temp_clamped[7:0];
								if (cur.tcnt < TEMP_DIGITS_MAX) begin
									nxt.tcnt = cur.tcnt + 2'd1;
								end
							end else if (cur.field == FLD_CONV_MIN) begin
								nxt.minutes = min_shift;
							end else if (sec_shift <= {1'b0, SEC_MAX}) begin
								nxt.seconds = sec_shift[5:0];
							end
						end else if (key_code == KEY_CLEAR) begin
							if (cur.field == FLD_CONV_TEMP) begin
								nxt.temp = '0;
								nxt.tcnt = '0;
							end else if (cur.field == FLD_CONV_MIN) begin
								nxt.minutes = '0;
							end else begin
								nxt.seconds = '0;
							end
						end else if (key_code == KEY_ENTER) begin
							if (cur.field == FLD_CONV_TEMP) begin
								nxt.field = FLD_CONV_MIN;
							end else if (cur.field == FLD_CONV_MIN) begin
								nxt.field = FLD_CONV_SEC;
							end else begin
								nxt.ctemp = cur.temp;
								nxt.tcnt  = '0;
								nxt.run   = 1'b1;
								nxt.pause = 1'b0;
								nxt.field = FLD_CONV_TEMP;
								nxt.mode  = MODE_RUN;
								nxt.fan   = 1'b1;
								nxt.ten   = 1'b1;
							end
						end
					end
					MODE_RUN: begin
						nxt.fan = 1'b1;
						if (key_code == KEY_START) begin
							nxt.run   = 1'b1;
							nxt.pause = 1'b0;
							nxt.ten   = 1'b1;
						end else if (key_code == KEY_PAUSE) begin
							nxt.run   = 1'b0;
							nxt.pause = 1'b1;
							nxt.ten   = 1'b0;
						end else if (key_code == KEY_STOP) begin
							nxt.run     = 1'b0;
							nxt.pause   = 1'b0;
							nxt.ten     = 1'b0;
							nxt.minutes = '0;
							nxt.seconds = '0;
							nxt.mode    = MODE_MENU;
						end
					end
					default: begin
					end
				endcase
			end
			ACT_TICK: begin
				// The minutes and seconds pair is the countdown itself while running.
				if (cur.run) begin
					if (cur.seconds != 6'd0) begin
						nxt.seconds = cur.seconds - 6'd1;
					end else if (cur.minutes != 7'd0) begin
						nxt.seconds = SEC_MAX;
						nxt.minutes = cur.minutes - 7'd1;
					end else begin
						nxt.ten   = 1'b0;
						nxt.run   = 1'b0;
						nxt.pause = 1'b0;
						nxt.field = '0;
						nxt.fan   = 1'b0;
						nxt.mode  = MODE_MENU;
						done      = 1'b1;
					end
				end
			end
			ACT_MENU: begin
				if (cur.mode == MODE_MENU) begin
					nxt.mode = menu_choice ? MODE_CONV : MODE_MICRO;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> verif/cook_timer_checker.sv
// ----------------------------------------------------------------------------
// cook_timer_checker
// Watches both streams of the cook-timer keypad controller. It keeps its own
// copy of the screen, entry and countdown state, works out the screen that
// each accepted event must produce, and compares every result item against
// the oldest outstanding prediction field by field.
// ----------------------------------------------------------------------------
module cook_timer_checker import ctkc_pkg::*; #(
	parameter int MAX_TEMP = MAX_TEMP_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] FIELD_FIRST = 2'd0;

	typedef struct packed {
		logic       done_pulse;
		logic       tick_enable;
		logic       fan_on;
		logic       paused;
		logic       running;
		logic [7:0] set_temp;
		logic [7:0] temp_entry;
		logic [5:0] seconds_shown;
		logic [6:0] minutes_shown;
		logic [1:0] edit_field;
		mode_t      screen_mode;
	} cook_screen_t;

	mode_t       mode_s;
	logic [1:0]  field_s;
	logic [6:0]  mins_s;
	logic [5:0]  secs_s;
	logic [7:0]  temp_s;
	logic [1:0]  digits_s;
	logic [12:0] left_s;
	logic [7:0]  set_temp_s;
	logic        run_s;
	logic        pause_s;
	logic        fan_s;
	logic        ten_s;

	cook_screen_t awaited_screens[$];

	function automatic void shift_minutes(input logic [3:0] k);
		int v;
		v = (mins_s % 10) * 10 + k;
		mins_s = v[6:0];
	endfunction

	function automatic void shift_seconds(input logic [3:0] k);
		int v;
		v = (secs_s % 10) * 10 + k;
		if (v <= SEC_MAX)
			secs_s = v[5:0];
	endfunction

	function automatic void start_cook();
		int total;
		total = mins_s * 60 + secs_s;
		left_s = total[12:0];
		run_s = 1'b1;
		pause_s = 1'b0;
		field_s = FIELD_FIRST;
		mode_s = MODE_RUN;
		fan_s = 1'b1;
		ten_s = 1'b1;
	endfunction

	function automatic void micro_key(input logic [3:0] k);
		if (k <= KEY_DIGIT_MAX) begin
			if (field_s == FLD_MICRO_MIN)
				shift_minutes(k);
			else
				shift_seconds(k);
		end else if (k == KEY_CLEAR) begin
			mins_s = '0;
			secs_s = '0;
			field_s = FLD_MICRO_MIN;
		end else if (k == KEY_ENTER) begin
			if (field_s == FLD_MICRO_MIN)
				field_s = FLD_MICRO_SEC;
			else
				start_cook();
		end
	endfunction

	function automatic void conv_key(input logic [3:0] k);
		int t;
		if (k <= KEY_DIGIT_MAX) begin
			if (field_s == FLD_CONV_TEMP) begin
				t = (digits_s == 2'd0) ? int'(k) : temp_s * 10 + k;
				if (t > MAX_TEMP)
					t = MAX_TEMP;
				temp_s = t[7:0];
				if (digits_s < TEMP_DIGITS_MAX)
					digits_s++;
			end else if (field_s == FLD_CONV_MIN) begin
				shift_minutes(k);
			end else begin
				shift_seconds(k);
			end
		end else if (k == KEY_CLEAR) begin
			if (field_s == FLD_CONV_TEMP) begin
				temp_s = '0;
				digits_s = '0;
			end else if (field_s == FLD_CONV_MIN) begin
				mins_s = '0;
			end else begin
				secs_s = '0;
			end
		end else if (k == KEY_ENTER) begin
			if (field_s == FLD_CONV_TEMP) begin
				field_s = FLD_CONV_MIN;
			end else if (field_s == FLD_CONV_MIN) begin
				field_s = FLD_CONV_SEC;
			end else begin
				set_temp_s = temp_s;
				digits_s = '0;
				start_cook();
			end
		end
	endfunction

	function automatic void run_key(input logic [3:0] k);
		fan_s = 1'b1;
		case (k)
			KEY_START: begin
				run_s = 1'b1;
				pause_s = 1'b0;
				ten_s = 1'b1;
			end
			KEY_PAUSE: begin
				run_s = 1'b0;
				pause_s = 1'b1;
				ten_s = 1'b0;
			end
			KEY_STOP: begin
				run_s = 1'b0;
				pause_s = 1'b0;
				ten_s = 1'b0;
				left_s = '0;
				mins_s = '0;
				secs_s = '0;
				mode_s = MODE_MENU;
			end
			default: ;
		endcase
	endfunction

	function automatic logic count_down();
		int q;
		if (!run_s)
			return 1'b0;
		if (left_s != '0) begin
			left_s--;
			q = left_s / 60;
			mins_s = q[6:0];
			q = left_s % 60;
			secs_s = q[5:0];
			return 1'b0;
		end
		ten_s = 1'b0;
		run_s = 1'b0;
		pause_s = 1'b0;
		field_s = FIELD_FIRST;
		if (mins_s == '0 && secs_s == '0)
			fan_s = 1'b0;
		mode_s = MODE_MENU;
		return 1'b1;
	endfunction

	function automatic cook_screen_t next_screen(input logic [1:0] act, input logic [3:0] k,
			input logic choice);
		cook_screen_t r;
		logic fin;
		fin = 1'b0;
		case (act)
			ACT_KEY: begin
				if (mode_s == MODE_MICRO)
					micro_key(k);
				else if (mode_s == MODE_CONV)
					conv_key(k);
				else if (mode_s == MODE_RUN)
					run_key(k);
			end
			ACT_TICK: begin
				fin = count_down();
			end
			ACT_MENU: begin
				if (mode_s == MODE_MENU) begin
					if (choice)
						mode_s = MODE_CONV;
					else
						mode_s = MODE_MICRO;
				end
			end
			default: ;
		endcase
		r.screen_mode = mode_s;
		r.edit_field = field_s;
		r.minutes_shown = mins_s;
		r.seconds_shown = secs_s;
		r.temp_entry = temp_s;
		r.set_temp = set_temp_s;
		r.running = run_s;
		r.paused = pause_s;
		r.fan_on = fan_s;
		r.tick_enable = ten_s;
		r.done_pulse = fin;
		return r;
	endfunction

	function automatic void compare_field(input string label, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", label, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : watch
		cook_screen_t seen;
		cook_screen_t want;
		if (!arst_n) begin
			mode_s = MODE_MENU;
			field_s = FIELD_FIRST;
			mins_s = '0;
			secs_s = '0;
			temp_s = '0;
			digits_s = '0;
			left_s = '0;
			set_temp_s = '0;
			run_s = 1'b0;
			pause_s = 1'b0;
			fan_s = 1'b0;
			ten_s = 1'b0;
			awaited_screens.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				seen = m_tdata[37:0];
				if (awaited_screens.size() == 0) begin
					$error("result item with no event outstanding: %h", m_tdata);
					mismatches++;
				end else begin
					want = awaited_screens.pop_front();
					compare_field("screen_mode", want.screen_mode, seen.screen_mode);
					compare_field("edit_field", want.edit_field, seen.edit_field);
					compare_field("minutes_shown", want.minutes_shown, seen.minutes_shown);
					compare_field("seconds_shown", want.seconds_shown, seen.seconds_shown);
					compare_field("temp_entry", want.temp_entry, seen.temp_entry);
					compare_field("set_temp", want.set_temp, seen.set_temp);
					compare_field("running", want.running, seen.running);
					compare_field("paused", want.paused, seen.paused);
					compare_field("fan_on", want.fan_on, seen.fan_on);
					compare_field("tick_enable", want.tick_enable, seen.tick_enable);
					compare_field("done_pulse", want.done_pulse, seen.done_pulse);
				end
			end
			if (s_tvalid && s_tready)
				awaited_screens.push_back(next_screen(s_tuser, s_tdata[3:0], s_tdata[4]));
		end
		outstanding <= awaited_screens.size();
	end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the cook-timer keypad controller testbench. A short directed run
// covers entry limits, rejected seconds, the temperature clamp and the
// running-screen keys; random cooks and bursts of noise follow, under
// phases of sender gaps and receiver stalls. The top reports the verdict
// from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ctkc_pkg::*;

	localparam logic [1:0] ACT_NONE       = 2'd3;
	localparam logic [3:0] KEY_NONE       = 4'd15;
	localparam logic [3:0] KEY_UNUSED     = 4'd12;
	localparam int         ITEM_TARGET    = 1400;
	localparam int         PHASE_ITEMS    = 120;
	localparam int         WATCHDOG_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	int          mismatches;
	int          outstanding;
	int          sender_gap = 0;
	int          receiver_stall = 0;
	int          items_sent = 0;

	always #5 clk = ~clk;

	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= receiver_stall);

	cook_timer_keypad_controller #(.MAX_TEMP(MAX_TEMP_DEFAULT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	cook_timer_checker #(.MAX_TEMP(MAX_TEMP_DEFAULT)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	task automatic send_item(input logic [1:0] act, input logic [3:0] key, input logic choice);
		case ((items_sent / PHASE_ITEMS) % 4)
			0: begin
				sender_gap = 0;
				receiver_stall = 0;
			end
			1: begin
				sender_gap = 72;
				receiver_stall = 0;
			end
			2: begin
				sender_gap = 0;
				receiver_stall = 72;
			end
			default: begin
				sender_gap = 21;
				receiver_stall = 21;
			end
		endcase
		if ($urandom_range(0, 99) < sender_gap) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < sender_gap);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {3'b000, choice, key};
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
	endtask

	task automatic press(input logic [3:0] key);
		send_item(ACT_KEY, key, 1'($urandom_range(0, 1)));
	endtask

	task automatic one_second();
		send_item(ACT_TICK, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
	endtask

	task automatic pick(input logic choice);
		send_item(ACT_MENU, 4'($urandom_range(0, 15)), choice);
	endtask

	task automatic type_number(input int value, input int digits);
		int div;
		div = 1;
		repeat ((digits > 1) ? digits - 1 : 0)
			div *= 10;
		while (digits > 0 && div > 0) begin
			press(4'((value / div) % 10));
			div /= 10;
		end
	endtask

	task automatic back_to_menu();
		repeat (3)
			press(KEY_ENTER);
		press(KEY_STOP);
	endtask

	task automatic random_cook();
		logic convection;
		int ticks;
		int r;
		convection = 1'($urandom_range(0, 1));
		pick(convection);
		if (convection) begin
			type_number($urandom_range(0, 999), $urandom_range(1, 4));
			if ($urandom_range(0, 9) == 0) begin
				press(KEY_CLEAR);
				type_number($urandom_range(0, 999), $urandom_range(0, 3));
			end
			press(KEY_ENTER);
		end
		type_number($urandom_range(0, 1), $urandom_range(0, 2));
		if ($urandom_range(0, 9) == 0)
			press(KEY_CLEAR);
		press(KEY_ENTER);
		type_number($urandom_range(0, 99), $urandom_range(0, 2));
		press(KEY_ENTER);
		ticks = $urandom_range(0, 90);
		repeat (ticks) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				press(KEY_PAUSE);
				one_second();
				press(KEY_START);
			end else if (r < 6) begin
				press(4'($urandom_range(0, 15)));
			end else begin
				one_second();
			end
		end
		press(KEY_STOP);
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(1, 8))
			send_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
				1'($urandom_range(0, 1)));
		back_to_menu();
	endtask

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		one_second();
		send_item(ACT_NONE, KEY_NONE, 1'b1);
		press(4'd7);
		pick(1'b0);
		pick(1'b1);
		press(4'd9);
		press(4'd9);
		press(KEY_UNUSED);
		press(KEY_ENTER);
		press(4'd5);
		press(4'd9);
		press(4'd9);
		press(KEY_ENTER);
		one_second();
		press(KEY_PAUSE);
		one_second();
		press(4'd3);
		press(KEY_START);
		press(KEY_STOP);
		pick(1'b1);
		press(4'd3);
		press(4'd0);
		press(4'd0);
		press(4'd7);
		press(KEY_CLEAR);
		back_to_menu();

		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 4) == 0)
				noise_burst();
			else
				random_cook();
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/ctkc_pkg.sv
hw/rtl/ctkc_next.sv
hw/rtl/cook_timer_keypad_controller.sv
verif/cook_timer_checker.sv
verif/tb.sv
